// ===== sv/i2cms_pkg.sv =====
// shared types and constants for the i2c master transfer sequencer
// no dependencies; imported by the top and i2cms_fsm (i2cms_buffer does not use it)
package i2cms_pkg;

    localparam int MAX_LEN = 32;
    // buffer address width and width of the byte counters
    localparam int BUF_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_EVENT = 2'd3
    } op_t;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_WR_START = 7'b0000010,
        PH_WR_ADDR  = 7'b0000100,
        PH_WR_DATA  = 7'b0001000,
        PH_RD_START = 7'b0010000,
        PH_RD_ADDR  = 7'b0100000,
        PH_RD_DATA  = 7'b1000000
    } phase_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] index;
        logic [7:0] data_byte;
        logic [6:0] dev_addr;
        logic [5:0] length;
        logic       flag_sb;
        logic       flag_addr;
        logic       flag_txe;
        logic       flag_btf;
        logic       flag_rxne;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_value;
        logic       start_gen;
        logic       stop_gen;
        logic       ack_update;
        logic       ack_enable;
        logic       status2_read;
        logic       rx_valid;
        logic [4:0] rx_index;
        logic [7:0] rx_value;
        logic       periph_enable;
        logic       busy_res;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

endpackage

// ===== sv/i2c_master_transfer_sequencer_top.sv =====
// top level of the i2c master transfer sequencer: stream ports, input and result registers
// depends on i2cms_pkg, i2cms_fsm and i2cms_buffer
//
// usage:
//   the input stream carries commands and engine events. tuser holds the op
//   (load transmit byte, start write, start read, hardware event); tdata holds
//   the buffer index, data byte, target address, length and the five status flags.
//   every accepted input transfer yields exactly one result transfer on the
//   output stream, holding the actions for the byte engine (byte to send,
//   start, stop, ack setting, status-2 read), any received byte with its
//   index, and the enable and busy state after that item.
//   each result passes through the input register, then the sequencer logic into
//   the result register. throughput: one item per cycle while the receiver does
//   not stall; the buffer read for the next byte position is issued ahead from
//   the next-state byte count, so a write byte is ready when its event comes.
//   reset (aresetn low, synchronous) empties both registers and returns the
//   sequencer to idle with the engine disabled; buffer contents stay undefined
//   until loaded.
//   when the receiver stalls, the result register holds, the input register
//   holds its item and s_tready drops once both are full; nothing is lost.
module i2c_master_transfer_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index[4:0], data_byte[12:5], dev_addr[19:13], length[25:20], flag_sb[26],
    // flag_addr[27], flag_txe[28], flag_btf[29], flag_rxne[30], zero[31]
    input  logic [31:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_valid[0], send_value[8:1], start_gen[9], stop_gen[10], ack_update[11],
    // ack_enable[12], status2_read[13], rx_valid[14], rx_index[19:15],
    // rx_value[27:20], periph_enable[28], busy_res[29], zero[31:30]
    output logic [31:0] m_tdata
);
    import i2cms_pkg::*;

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t res;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic                  advance;
    logic                  step;
    logic [BUF_AW-1:0]     rd_addr;
    logic [7:0]            rd_data;
    buf_wr_t               wr;

    // the result register frees up when empty or when its transfer completes
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.op        <= op_t'(s_tuser);
            in_reg.index     <= s_tdata[4:0];
            in_reg.data_byte <= s_tdata[12:5];
            in_reg.dev_addr  <= s_tdata[19:13];
            in_reg.length    <= s_tdata[25:20];
            in_reg.flag_sb   <= s_tdata[26];
            in_reg.flag_addr <= s_tdata[27];
            in_reg.flag_txe  <= s_tdata[28];
            in_reg.flag_btf  <= s_tdata[29];
            in_reg.flag_rxne <= s_tdata[30];
        end
    end

    // sequencer and buffer
    i2cms_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr      (wr),
        .res     (res)
    );

    i2cms_buffer #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_buffer (
        .aclk    (aclk),
        .we      (wr.we),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.busy_res,
                       out_reg.periph_enable,
                       out_reg.rx_value,
                       out_reg.rx_index,
                       out_reg.rx_valid,
                       out_reg.status2_read,
                       out_reg.ack_enable,
                       out_reg.ack_update,
                       out_reg.stop_gen,
                       out_reg.start_gen,
                       out_reg.send_value,
                       out_reg.send_valid};

endmodule

// ===== sv/i2cms_buffer.sv =====
// generic ram with one write port and one registered read port, write-first on an address match
// no dependencies; width and depth are set by the instantiating module
module i2cms_buffer #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        // a read of the address being written returns the new value
        if (we && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/i2cms_fsm.sv =====
// transfer sequencer state machine: phase, address, length, byte count
// depends on i2cms_pkg; reads and writes the buffer through i2cms_buffer
module i2cms_fsm (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  i2cms_pkg::in_item_t              item,
    input  logic [7:0]                       rd_data,
    output logic [i2cms_pkg::BUF_AW-1:0]     rd_addr,
    output i2cms_pkg::buf_wr_t               wr,
    output i2cms_pkg::out_item_t             res
);
    import i2cms_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [6:0]       addr_reg, addr_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] done_reg, done_next;
    logic             engine_reg, engine_next;

    logic [CNT_W-1:0] len_sat;
    logic [CNT_W-1:0] done_inc;
    logic             done_in_buf;
    logic [7:0]       tx_byte;

    // registered read: fetch the byte position the next item will see
    assign rd_addr     = (aresetn && step) ? done_next[BUF_AW-1:0] : done_reg[BUF_AW-1:0];
    assign done_in_buf = 32'(done_reg) < 32'(MAX_LEN);
    assign tx_byte     = done_in_buf ? rd_data : 8'd0;
    assign done_inc    = done_reg + CNT_W'(1);

    always_comb begin
        if (item.length == 6'd0) begin
            len_sat = CNT_W'(1);
        end else if (32'(item.length) > 32'(MAX_LEN)) begin
            len_sat = CNT_W'(MAX_LEN);
        end else begin
            len_sat = CNT_W'(item.length);
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        done_next   = done_reg;
        engine_next = engine_reg;
        wr          = '0;
        res         = '0;

        case (item.op)
            OP_LOAD: begin
                if (32'(item.index) < 32'(MAX_LEN)) begin
                    wr.we   = 1'b1;
                    wr.addr = BUF_AW'(item.index);
                    wr.data = item.data_byte;
                end
            end
            OP_WRITE, OP_READ: begin
                addr_next     = item.dev_addr;
                len_next      = len_sat;
                done_next     = '0;
                engine_next   = 1'b1;
                phase_next    = (item.op == OP_WRITE) ? PH_WR_START : PH_RD_START;
                res.start_gen = 1'b1;
            end
            default: begin
                case (phase_reg)
                    PH_WR_START: begin
                        if (item.flag_sb) begin
                            res.send_valid = 1'b1;
                            res.send_value = {addr_reg, 1'b0};
                            phase_next     = PH_WR_ADDR;
                        end
                    end
                    PH_WR_ADDR: begin
                        if (item.flag_addr) begin
                            res.status2_read = 1'b1;
                            res.send_valid   = 1'b1;
                            res.send_value   = tx_byte;
                            done_next        = done_inc;
                            phase_next       = PH_WR_DATA;
                        end
                    end
                    PH_WR_DATA: begin
                        if (item.flag_txe || item.flag_btf) begin
                            if (done_reg < len_reg) begin
                                res.send_valid = 1'b1;
                                res.send_value = tx_byte;
                                done_next      = done_inc;
                            end else if (item.flag_btf) begin
                                res.stop_gen = 1'b1;
                                engine_next  = 1'b0;
                                phase_next   = PH_IDLE;
                            end
                        end
                    end
                    PH_RD_START: begin
                        if (item.flag_sb) begin
                            res.send_valid = 1'b1;
                            res.send_value = {addr_reg, 1'b1};
                            phase_next     = PH_RD_ADDR;
                        end
                    end
                    PH_RD_ADDR: begin
                        if (item.flag_addr) begin
                            res.ack_update   = 1'b1;
                            res.ack_enable   = (len_reg != CNT_W'(1));
                            res.status2_read = 1'b1;
                            res.stop_gen     = (len_reg == CNT_W'(1));
                            phase_next       = PH_RD_DATA;
                        end
                    end
                    PH_RD_DATA: begin
                        if (item.flag_rxne) begin
                            // received byte lands in the buffer at its message position
                            wr.we        = done_in_buf;
                            wr.addr      = done_reg[BUF_AW-1:0];
                            wr.data      = item.data_byte;
                            res.rx_valid = 1'b1;
                            res.rx_index = 5'(done_reg);
                            res.rx_value = item.data_byte;
                            done_next    = done_inc;
                            if (done_inc >= len_reg) begin
                                res.stop_gen = (len_reg > CNT_W'(1));
                                engine_next  = 1'b0;
                                phase_next   = PH_IDLE;
                            end else if (done_inc + CNT_W'(1) == len_reg) begin
                                // one byte left: nack it and queue the stop
                                res.ack_update = 1'b1;
                                res.ack_enable = 1'b0;
                                res.stop_gen   = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        if (!step) begin
            wr.we = 1'b0;
        end
        res.periph_enable = engine_next;
        res.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            addr_reg   <= '0;
            len_reg    <= '0;
            done_reg   <= '0;
            engine_reg <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            len_reg    <= len_next;
            done_reg   <= done_next;
            engine_reg <= engine_next;
        end
    end

endmodule

// ===== dv/i2cms_tb_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the i2c master transfer sequencer: predicts the action word for each input transfer
// depends on i2cms_pkg for the item types, phases, ops and MAX_LEN
package i2cms_tb_pkg;
    import i2cms_pkg::*;

    class sequencer_scoreboard;
        phase_t            phase;
        logic [6:0]        target;
        int                msg_len;
        int                done_cnt;
        bit                engine_on;
        logic [7:0]        msg_buf [MAX_LEN];
        bit [MAX_LEN-1:0]  loaded;
        out_item_t         pending_actions [$];
        int                mismatches;
        int                checked;
        int                writes_closed;
        int                reads_closed;
        int                restarts;
        int                rx_bytes;

        function new();
            phase = PH_IDLE;
            target = '0;
            msg_len = 0;
            done_cnt = 0;
            engine_on = 1'b0;
            loaded = '0;
            mismatches = 0;
            checked = 0;
            writes_closed = 0;
            reads_closed = 0;
            restarts = 0;
            rx_bytes = 0;
        endfunction

        function void open_message(logic [6:0] addr, logic [5:0] len, phase_t first);
            if (phase != PH_IDLE) restarts++;
            msg_len = (len == 0) ? 1 : int'(len);
            if (msg_len > MAX_LEN) msg_len = MAX_LEN;
            target = addr;
            done_cnt = 0;
            phase = first;
            engine_on = 1'b1;
        endfunction

        function logic [7:0] next_tx_byte();
            logic [7:0] v;
            v = 8'h00;
            if (done_cnt < MAX_LEN) v = msg_buf[done_cnt];
            done_cnt++;
            return v;
        endfunction

        // advance the sequencer by one accepted transfer and queue the expected actions
        function void take_command(in_item_t it);
            out_item_t r;
            r = '0;
            case (it.op)
                OP_LOAD: begin
                    if (int'(it.index) < MAX_LEN) begin
                        msg_buf[it.index] = it.data_byte;
                        loaded[it.index] = 1'b1;
                    end
                end
                OP_WRITE: begin
                    open_message(it.dev_addr, it.length, PH_WR_START);
                    r.start_gen = 1'b1;
                end
                OP_READ: begin
                    open_message(it.dev_addr, it.length, PH_RD_START);
                    r.start_gen = 1'b1;
                end
                default: begin
                    case (phase)
                        PH_WR_START: begin
                            if (it.flag_sb) begin
                                r.send_valid = 1'b1;
                                r.send_value = {target, 1'b0};
                                phase = PH_WR_ADDR;
                            end
                        end
                        PH_WR_ADDR: begin
                            if (it.flag_addr) begin
                                r.status2_read = 1'b1;
                                phase = PH_WR_DATA;
                                r.send_valid = 1'b1;
                                r.send_value = next_tx_byte();
                            end
                        end
                        PH_WR_DATA: begin
                            if (it.flag_txe || it.flag_btf) begin
                                if (done_cnt < msg_len) begin
                                    r.send_valid = 1'b1;
                                    r.send_value = next_tx_byte();
                                end else if (it.flag_btf) begin
                                    r.stop_gen = 1'b1;
                                    engine_on = 1'b0;
                                    phase = PH_IDLE;
                                    writes_closed++;
                                end
                            end
                        end
                        PH_RD_START: begin
                            if (it.flag_sb) begin
                                r.send_valid = 1'b1;
                                r.send_value = {target, 1'b1};
                                phase = PH_RD_ADDR;
                            end
                        end
                        PH_RD_ADDR: begin
                            if (it.flag_addr) begin
                                r.ack_update = 1'b1;
                                r.ack_enable = (msg_len != 1);
                                r.status2_read = 1'b1;
                                r.stop_gen = (msg_len == 1);
                                phase = PH_RD_DATA;
                            end
                        end
                        PH_RD_DATA: begin
                            if (it.flag_rxne) begin
                                if (done_cnt < MAX_LEN) begin
                                    msg_buf[done_cnt] = it.data_byte;
                                    loaded[done_cnt] = 1'b1;
                                end
                                r.rx_valid = 1'b1;
                                r.rx_index = 5'(done_cnt);
                                r.rx_value = it.data_byte;
                                rx_bytes++;
                                done_cnt++;
                                if (done_cnt >= msg_len) begin
                                    r.stop_gen = (msg_len > 1);
                                    engine_on = 1'b0;
                                    phase = PH_IDLE;
                                    reads_closed++;
                                end else if (done_cnt + 1 == msg_len) begin
                                    r.ack_update = 1'b1;
                                    r.ack_enable = 1'b0;
                                    r.stop_gen = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            r.periph_enable = engine_on;
            r.busy_res = (phase != PH_IDLE);
            pending_actions.push_back(r);
        endfunction

        function logic [31:0] to_word(out_item_t o);
            logic [31:0] w;
            w = '0;
            w[0]     = o.send_valid;
            w[8:1]   = o.send_value;
            w[9]     = o.start_gen;
            w[10]    = o.stop_gen;
            w[11]    = o.ack_update;
            w[12]    = o.ack_enable;
            w[13]    = o.status2_read;
            w[14]    = o.rx_valid;
            w[19:15] = o.rx_index;
            w[27:20] = o.rx_value;
            w[28]    = o.periph_enable;
            w[29]    = o.busy_res;
            return w;
        endfunction

        // compare one result transfer against the oldest queued expectation
        function void check_response(logic [31:0] w);
            out_item_t want;
            string     diff;
            checked++;
            if (pending_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: actual %h, nothing queued", checked, w);
                return;
            end
            want = pending_actions.pop_front();
            diff = "";
            if (w[0]     !== want.send_valid)    diff = {diff, " send_valid"};
            if (w[8:1]   !== want.send_value)    diff = {diff, " send_value"};
            if (w[9]     !== want.start_gen)     diff = {diff, " start_gen"};
            if (w[10]    !== want.stop_gen)      diff = {diff, " stop_gen"};
            if (w[11]    !== want.ack_update)    diff = {diff, " ack_update"};
            if (w[12]    !== want.ack_enable)    diff = {diff, " ack_enable"};
            if (w[13]    !== want.status2_read)  diff = {diff, " status2_read"};
            if (w[14]    !== want.rx_valid)      diff = {diff, " rx_valid"};
            if (w[19:15] !== want.rx_index)      diff = {diff, " rx_index"};
            if (w[27:20] !== want.rx_value)      diff = {diff, " rx_value"};
            if (w[28]    !== want.periph_enable) diff = {diff, " periph_enable"};
            if (w[29]    !== want.busy_res)      diff = {diff, " busy_res"};
            if (w[31:30] !== 2'b00)              diff = {diff, " pad"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d:%s expected %h actual %h",
                             checked, diff, to_word(want), w);
            end
        endfunction

        function int outstanding();
            return pending_actions.size();
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// top testbench for i2c_master_transfer_sequencer_top: drives command and event streams
// depends on i2cms_pkg, i2cms_tb_pkg and the rtl of the block
module tb_top;
    import i2cms_pkg::*;
    import i2cms_tb_pkg::*;

    // input transfers sent before the random part stops
    localparam int ITEM_TARGET = 950;
    // upper bound for the watchdog, with plenty of slack for the slowest legal run
    localparam int CYCLE_LIMIT = 400000;

    // flag masks in the order sb, addr, txe, btf, rxne
    localparam logic [4:0] F_SB   = 5'b10000;
    localparam logic [4:0] F_AD   = 5'b01000;
    localparam logic [4:0] F_TXE  = 5'b00100;
    localparam logic [4:0] F_BTF  = 5'b00010;
    localparam logic [4:0] F_RXNE = 5'b00001;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    sequencer_scoreboard board;
    int n_sent;
    int n_ignored;
    int burst_left;
    int cycles;
    int rx_mode;
    int rx_hold;

    i2c_master_transfer_sequencer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still queued",
                     cycles, board.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: every accepted transfer is checked against the prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_response(m_tdata);
    end

    // receiver stall pattern: switches between always ready, mostly ready,
    // mostly stalled and a fixed 5-of-8 duty cycle
    always @(negedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_hold <= $urandom_range(32, 200);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles % 8) < 5);
        endcase
    end

    // tdata layout: index, data_byte, dev_addr, length, then the five flags
    function automatic logic [31:0] to_tdata(in_item_t it);
        return {1'b0, it.flag_rxne, it.flag_btf, it.flag_txe, it.flag_addr, it.flag_sb,
                it.length, it.dev_addr, it.data_byte, it.index};
    endfunction

    function automatic in_item_t rnd_item();
        in_item_t it;
        it.op        = op_t'($urandom_range(0, 3));
        it.index     = 5'($urandom_range(0, 31));
        it.data_byte = 8'($urandom_range(0, 255));
        it.dev_addr  = 7'($urandom_range(0, 127));
        it.length    = 6'($urandom_range(0, 63));
        {it.flag_sb, it.flag_addr, it.flag_txe, it.flag_btf, it.flag_rxne} =
            5'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic in_item_t ld(logic [4:0] idx, logic [7:0] db);
        in_item_t it;
        it = rnd_item();
        it.op = OP_LOAD;
        it.index = idx;
        it.data_byte = db;
        return it;
    endfunction

    function automatic in_item_t cmd(op_t op, logic [6:0] addr, logic [5:0] len);
        in_item_t it;
        it = rnd_item();
        it.op = op;
        it.dev_addr = addr;
        it.length = len;
        return it;
    endfunction

    function automatic in_item_t ev(logic [4:0] fl, logic [7:0] db);
        in_item_t it;
        it = rnd_item();
        it.op = OP_EVENT;
        it.data_byte = db;
        {it.flag_sb, it.flag_addr, it.flag_txe, it.flag_btf, it.flag_rxne} = fl;
        return it;
    endfunction

    function automatic logic [4:0] rnd_flags();
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [5:0] rnd_len();
        // mostly short messages, now and then anything up to the saturating range
        if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, 8));
    endfunction

    // one transfer on the input side, with bursty gaps between groups of items;
    // entered and left at a falling edge, valid stays high into the next item
    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= to_tdata(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_command(it);
        n_sent++;
        @(negedge aclk);
    endtask

    // a write start reads the buffer up to its length, so any entry never
    // loaded below that length gets a load first
    task automatic issue(in_item_t it);
        int eff;
        if (it.op == OP_WRITE) begin
            eff = (it.length == 0) ? 1 : int'(it.length);
            if (eff > MAX_LEN) eff = MAX_LEN;
            for (int i = 0; i < eff; i++)
                if (!board.loaded[i]) send_item(ld(5'(i), 8'($urandom_range(0, 255))));
        end
        send_item(it);
    endtask

    // event whose relevant flags are all clear, so the block does nothing
    task automatic noise(logic [4:0] mask);
        issue(ev(rnd_flags() & ~mask, 8'($urandom_range(0, 255))));
        n_ignored++;
    endtask

    task automatic maybe_noise(logic [4:0] mask);
        if ($urandom_range(0, 7) == 0) noise(mask);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // well-formed write message with random content; may be cut short,
    // in which case the next start restarts the sequencer
    task automatic run_write();
        logic [5:0] len;
        int         eff;
        logic [4:0] fl;
        repeat ($urandom_range(0, 3))
            issue(ld(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))));
        len = rnd_len();
        eff = (len == 0) ? 1 : ((len > MAX_LEN) ? MAX_LEN : int'(len));
        issue(cmd(OP_WRITE, 7'($urandom_range(0, 127)), len));
        maybe_noise(F_SB);
        issue(ev(rnd_flags() | F_SB, 8'($urandom_range(0, 255))));
        maybe_noise(F_AD);
        issue(ev(rnd_flags() | F_AD, 8'($urandom_range(0, 255))));
        for (int i = 1; i < eff; i++) begin
            if ($urandom_range(0, 39) == 0) return;
            if ($urandom_range(0, 9) == 0)
                issue(ld(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))));
            maybe_noise(F_TXE | F_BTF);
            // txe, btf or both move the next byte
            fl = rnd_flags() & ~(F_TXE | F_BTF);
            case ($urandom_range(1, 3))
                1: fl = fl | F_TXE;
                2: fl = fl | F_BTF;
                default: fl = fl | F_TXE | F_BTF;
            endcase
            issue(ev(fl, 8'($urandom_range(0, 255))));
        end
        // all bytes queued: txe alone only waits for btf
        if ($urandom_range(0, 1) == 0)
            issue(ev((rnd_flags() & ~F_BTF) | F_TXE, 8'($urandom_range(0, 255))));
        maybe_noise(F_TXE | F_BTF);
        issue(ev(rnd_flags() | F_BTF, 8'($urandom_range(0, 255))));
    endtask

    task automatic run_read();
        logic [5:0] len;
        int         eff;
        len = rnd_len();
        eff = (len == 0) ? 1 : ((len > MAX_LEN) ? MAX_LEN : int'(len));
        issue(cmd(OP_READ, 7'($urandom_range(0, 127)), len));
        maybe_noise(F_SB);
        issue(ev(rnd_flags() | F_SB, 8'($urandom_range(0, 255))));
        maybe_noise(F_AD);
        issue(ev(rnd_flags() | F_AD, 8'($urandom_range(0, 255))));
        for (int i = 0; i < eff; i++) begin
            if ($urandom_range(0, 39) == 0) return;
            if ($urandom_range(0, 9) == 0)
                issue(ld(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))));
            maybe_noise(F_RXNE);
            issue(ev(rnd_flags() | F_RXNE, 8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        int pick;
        board = new();
        n_sent = 0;
        n_ignored = 0;
        burst_left = 0;
        cycles = 0;
        rx_mode = 0;
        rx_hold = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: buffer extremes, event while idle
        issue(ld(5'd0, 8'hA5));
        issue(ld(5'd1, 8'h00));
        issue(ld(5'd31, 8'hFF));
        issue(ev(5'b11111, 8'hFF));
        // zero length write to the top address, wrong flag first, txe wait, then stop
        issue(cmd(OP_WRITE, 7'h7F, 6'd0));
        issue(ev(F_AD | F_TXE | F_BTF | F_RXNE, 8'h00));
        issue(ev(F_SB, 8'h00));
        issue(ev(F_AD, 8'h00));
        issue(ev(F_TXE, 8'h00));
        issue(ev(F_BTF, 8'h00));
        // single byte read from address zero: nack and stop on the address event
        issue(cmd(OP_READ, 7'h00, 6'd1));
        issue(ev(F_SB, 8'h00));
        issue(ev(F_AD, 8'h00));
        issue(ev(F_RXNE, 8'hFF));
        // oversized read, then a write start while it is still busy
        issue(cmd(OP_READ, 7'h55, 6'd63));
        issue(ev(F_SB, 8'h00));
        issue(ev(F_AD, 8'h00));
        issue(ev(F_RXNE, 8'h00));
        issue(ev(F_RXNE, 8'h3C));
        issue(cmd(OP_WRITE, 7'h2A, 6'd2));
        issue(ev(F_SB, 8'h00));
        issue(ev(F_AD, 8'h00));
        issue(ev(F_TXE, 8'h00));
        issue(ev(F_BTF, 8'h00));
        // two byte read: nack armed after the first byte
        issue(cmd(OP_READ, 7'h01, 6'd2));
        issue(ev(F_SB, 8'h00));
        issue(ev(F_AD, 8'h00));
        issue(ev(F_RXNE, 8'h81));
        issue(ev(F_RXNE, 8'h7E));
        pause_until_drained();

        // random: mostly complete messages, some raw items and stray events
        while (n_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
                run_write();
            else if (pick < 84)
                run_read();
            else if (pick < 94)
                issue(rnd_item());
            else
                noise(5'b11111);
            if ($urandom_range(0, 59) == 0) pause_until_drained();
        end

        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("run covered %0d input transfers (%0d no-op events), %0d results checked",
                 n_sent, n_ignored, board.checked);
        $display("messages: %0d writes and %0d reads closed, %0d restarts, %0d bytes in, %0d bad",
                 board.writes_closed, board.reads_closed, board.restarts, board.rx_bytes,
                 board.mismatches);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/i2cms_pkg.sv
sv/i2cms_buffer.sv
sv/i2cms_fsm.sv
sv/i2c_master_transfer_sequencer_top.sv
dv/i2cms_tb_pkg.sv
dv/tb_top.sv
